@@ rtl/core/srd_pkg.sv @@
// Shared constants, types and command/status structures of the scanline RLE decoder.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;
  localparam int REM_W      = 7;
  localparam int POS_W      = 13;
  localparam int OUT_W      = 64;
  localparam int MAX_LANES  = OUT_W / BYTE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int unsigned DEF_MAX_WIDTH = 4096;
  localparam int unsigned DEF_LANES     = 8;

  localparam logic [CFG_IDX_W-1:0]  REG_RLE_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_ROW_WIDTH   = 1'b1;
  localparam logic [POS_W-1:0]      RESET_ROW_WIDTH = 13'd4096;

  // Which kind of result the datapath builds when the controller loads the output.
  typedef enum logic [1:0] {
    KIND_VERB  = 2'd0,
    KIND_LIT   = 2'd1,
    KIND_END   = 2'd2,
    KIND_CHUNK = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic      out_load;
    out_kind_t kind;
    logic      cnt_load;
    logic      cnt_dec;
    logic      run_start;
  } srd_cmd_t;

  typedef struct packed {
    logic rle_mode;
    logic hdr_zero;
    logic hdr_literal;
    logic rem_le_one;
    logic run_last;
  } srd_stat_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_bytes;
    logic [CNT_W-1:0] byte_count;
    logic             run_last;
    logic             row_end;
    logic             overflow;
    logic [POS_W-1:0] row_position;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/srd_if.sv @@
// Handshake channel interfaces: compressed input, decoded output and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface srd_in_if import srd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface srd_out_if import srd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_bytes;
  logic [CNT_W-1:0] byte_count;
  logic             run_last;
  logic             row_end;
  logic             overflow;
  logic [POS_W-1:0] row_position;

  modport source (output valid, output out_bytes, output byte_count, output run_last,
                  output row_end, output overflow, output row_position, input ready);
  modport sink   (input valid, input out_bytes, input byte_count, input run_last,
                  input row_end, input overflow, input row_position, output ready);
endinterface

interface srd_cfg_if import srd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/srd_ctrl.sv @@
// Controller state machine: decode phase, run emission sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

module srd_ctrl import srd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire srd_stat_t stat,
  output srd_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_HEADER  = 4'b0001,
    ST_LITERAL = 4'b0010,
    ST_RUNVAL  = 4'b0100,
    ST_RUN     = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state != ST_RUN) && slot_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = KIND_VERB;
    if (accept && !stat.rle_mode) begin
      cmd.out_load = 1'b1;
      cmd.kind     = KIND_VERB;
    end else begin
      unique case (state)
        ST_HEADER: begin
          if (accept) begin
            if (stat.hdr_zero) begin
              cmd.out_load = 1'b1;
              cmd.kind     = KIND_END;
            end else begin
              cmd.cnt_load = 1'b1;
              state_next   = stat.hdr_literal ? ST_LITERAL : ST_RUNVAL;
            end
          end
        end
        ST_LITERAL: begin
          if (accept) begin
            cmd.out_load = 1'b1;
            cmd.kind     = KIND_LIT;
            cmd.cnt_dec  = 1'b1;
            if (stat.rem_le_one) begin
              state_next = ST_HEADER;
            end
          end
        end
        ST_RUNVAL: begin
          if (accept) begin
            cmd.run_start = 1'b1;
            state_next    = ST_RUN;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            cmd.kind     = KIND_CHUNK;
            if (stat.run_last) begin
              state_next = ST_HEADER;
            end
          end
        end
        default: begin
          state_next = ST_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HEADER;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !in_ready)
    else $error("input accepted while a run is being emitted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free)
    else $error("pending result overwritten");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && slot_free && stat.run_last) |=> state == ST_HEADER)
    else $error("run did not return to header phase after its last word");

endmodule

`default_nettype wire

@@ rtl/core/srd_dp.sv @@
// Datapath: registers, row position, run counter, lane packing and output word register.
`timescale 1ns / 1ps
`default_nettype none

module srd_dp import srd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int unsigned LANES     = DEF_LANES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  wire srd_cmd_t              cmd,
  output srd_stat_t                  stat,
  output out_word_t                  word
);

  localparam logic [REM_W-1:0] LANES_R = REM_W'(LANES);

  logic             rle_mode;
  logic [POS_W-1:0] row_width;
  logic [POS_W-1:0] position, position_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [BYTE_W-1:0] run_val;

  logic [POS_W-1:0]  eff_w;
  logic [POS_W-1:0]  room;
  logic [REM_W-1:0]  chunk;
  logic [BYTE_W-1:0] lane_val;
  logic              short;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W:0]    pos_inc;
  logic              verb_end;
  out_word_t         word_next;

  // Width 0 behaves as 1, anything above the build limit as the limit.
  always_comb begin
    if (row_width == '0) begin
      eff_w = POS_W'(1);
    end else if (17'(row_width) > 17'(MAX_WIDTH)) begin
      eff_w = POS_W'(MAX_WIDTH);
    end else begin
      eff_w = row_width;
    end
  end

  assign room     = (position < eff_w) ? (eff_w - position) : '0;
  assign chunk    = (cmd.kind == KIND_LIT) ? REM_W'(1)
                  : ((remaining > LANES_R) ? LANES_R : remaining);
  assign lane_val = (cmd.kind == KIND_LIT) ? in_byte : run_val;
  assign short    = POS_W'(chunk) > room;
  assign cnt      = short ? room[CNT_W-1:0] : chunk[CNT_W-1:0];
  assign pos_inc  = {1'b0, position} + (POS_W+1)'(1);
  assign verb_end = pos_inc >= {1'b0, eff_w};

  assign stat.rle_mode    = rle_mode;
  assign stat.hdr_zero    = (in_byte[REM_W-1:0] == '0);
  assign stat.hdr_literal = in_byte[BYTE_W-1];
  assign stat.rem_le_one  = (remaining <= REM_W'(1));
  assign stat.run_last    = (remaining <= LANES_R);

  always_comb begin
    word_next      = '0;
    position_next  = position;
    remaining_next = remaining;
    if (cmd.cnt_load) begin
      remaining_next = in_byte[REM_W-1:0];
    end else if (cmd.cnt_dec && remaining != '0) begin
      remaining_next = remaining - REM_W'(1);
    end
    unique case (cmd.kind)
      KIND_VERB: begin
        word_next.out_bytes    = OUT_W'(in_byte);
        word_next.byte_count   = CNT_W'(1);
        word_next.run_last     = 1'b1;
        word_next.row_end      = verb_end;
        word_next.row_position = pos_inc[POS_W-1:0];
        position_next          = verb_end ? '0 : pos_inc[POS_W-1:0];
      end
      KIND_END: begin
        word_next.run_last     = 1'b1;
        word_next.row_end      = 1'b1;
        word_next.row_position = position;
        position_next          = '0;
      end
      KIND_LIT, KIND_CHUNK: begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if (CNT_W'(i) < cnt) begin
            word_next.out_bytes[i*BYTE_W +: BYTE_W] = lane_val;
          end
        end
        word_next.byte_count   = cnt;
        word_next.run_last     = (cmd.kind == KIND_LIT) || (remaining <= LANES_R);
        word_next.overflow     = short;
        word_next.row_position = position + POS_W'(cnt);
        position_next          = position + POS_W'(cnt);
        if (cmd.kind == KIND_CHUNK) begin
          remaining_next = remaining - chunk;
        end
      end
      default: begin
        word_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode  <= 1'b1;
      row_width <= RESET_ROW_WIDTH;
      position  <= '0;
      remaining <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RLE_MODE:  rle_mode  <= cfg_data[0];
          REG_ROW_WIDTH: row_width <= cfg_data;
          default:       rle_mode  <= rle_mode;
        endcase
      end
      if (cmd.out_load) begin
        position <= position_next;
      end
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      run_val <= in_byte;
    end
    if (cmd.out_load) begin
      word <= word_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> word.byte_count <= CNT_W'(LANES))
    else $error("result carries more bytes than lanes");

endmodule

`default_nettype wire

@@ rtl/core/scanline_rle_decoder_top.sv @@
// Top level of the scanline RLE decoder: channel wiring, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                                    Word accepted when
// din      in   in_byte[7:0]                                               din.valid & din.ready
// dout     out  out_bytes[63:0] byte_count run_last row_end overflow
//               row_position[12:0]                                         dout.valid & dout.ready
// cfg      in   index[0] (0 rle_mode, 1 row_width), data[12:0]            cfg.valid & cfg.ready
//
// The decoder accepts header, literal and verbatim words at one per cycle while the output
// register is free or being drained.
// A run value word is latched first; the run counter then issues one output word per cycle
// while the output register is free or being drained, and din is held off meanwhile.
// Synchronous active-high reset restores rle_mode 1, row_width 4096, header phase,
// an empty run counter and row position zero; no clearing pass is needed.
// A stalled dout holds its word and backs up into din; cfg is always ready.
module scanline_rle_decoder_top import srd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int unsigned LANES     = DEF_LANES
) (
  input wire logic   clk,
  input wire logic   rst,
  srd_in_if.sink     din,
  srd_out_if.source  dout,
  srd_cfg_if.sink    cfg
);

  srd_cmd_t  cmd;
  srd_stat_t stat;
  out_word_t word;

  // Register writes are taken at once; issue them only while the decoder is idle (not enforced).
  assign cfg.ready = 1'b1;

  srd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srd_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .LANES     (LANES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .in_byte   (din.in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .word      (word)
  );

  // The output register lives in the datapath; its fields map straight onto dout.
  assign dout.out_bytes    = word.out_bytes;
  assign dout.byte_count   = word.byte_count;
  assign dout.run_last     = word.run_last;
  assign dout.row_end      = word.row_end;
  assign dout.overflow     = word.overflow;
  assign dout.row_position = word.row_position;

endmodule

`default_nettype wire
